[rtl/bzf_pkg.sv]
package bzf_pkg;

    localparam int DEF_MAX_DEPTH  = 6;
    localparam int DEF_COORD_BITS = 12;
    localparam int LIMIT_W        = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd1;

endpackage

[rtl/bzf_mul.sv]
module bzf_mul #(
    parameter int W = 28
) (
    input  logic                  i_clk,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_p
);

    logic signed [2*W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

[rtl/bzf_stk.sv]
module bzf_stk #(
    parameter int DEPTH = 7,
    parameter int DW    = 51
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/cubic_bezier_flatten_core.sv]
// A tested node passes S_TEST, S_AA to S_NN and S_CMP; it is split when its first inner point
// is far, without testing the second. A node at MAX_DEPTH is emitted untested, and each pop
// from the stack passes S_POP and S_LOAD. All products come from one shared multiplier.
// One curve is handled at a time, up to 2^(MAX_DEPTH+1)-1 nodes; a new curve is taken once
// the last word of the previous one is issued. Output stalls hold the sequencer in S_EMIT.
// Reset is synchronous and active low; it clears the sequencer, stack pointer and output valid.
module cubic_bezier_flatten_core #(
    parameter int MAX_DEPTH  = bzf_pkg::DEF_MAX_DEPTH,
    parameter int COORD_BITS = bzf_pkg::DEF_COORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bzf_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [COORD_BITS-1:0]       i_p0_x,
    input  logic [COORD_BITS-1:0]       i_p0_y,
    input  logic [COORD_BITS-1:0]       i_p1_x,
    input  logic [COORD_BITS-1:0]       i_p1_y,
    input  logic [COORD_BITS-1:0]       i_p2_x,
    input  logic [COORD_BITS-1:0]       i_p2_y,
    input  logic [COORD_BITS-1:0]       i_p3_x,
    input  logic [COORD_BITS-1:0]       i_p3_y,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [COORD_BITS-1:0]       o_seg_x0,
    output logic [COORD_BITS-1:0]       o_seg_y0,
    output logic [COORD_BITS-1:0]       o_seg_x1,
    output logic [COORD_BITS-1:0]       o_seg_y1,
    output logic                        o_seg_last
);

    localparam int C    = COORD_BITS;
    localparam int DW   = C + 1;
    localparam int MW   = 2 * C + 4;
    localparam int PW   = 2 * MW;
    localparam int SD   = MAX_DEPTH + 1;
    localparam int IW   = $clog2(SD);
    localparam int SPW  = $clog2(SD + 1);
    localparam int LW   = $clog2(MAX_DEPTH + 1);
    localparam int EW   = LW + 8 * C;

    typedef enum logic [3:0] {
        S_IDLE, S_TEST, S_AA, S_BB, S_LL, S_LS, S_RH, S_NA, S_NB, S_NS,
        S_NN, S_CMP, S_SPLIT, S_EMIT, S_POP, S_LOAD
    } t_state;

    t_state                  r_state;
    logic [C-1:0]            r_px [4];
    logic [C-1:0]            r_py [4];
    logic [LW-1:0]           r_lvl;
    logic [SPW-1:0]          r_sp;
    logic                    r_k;
    logic signed [MW-1:0]    r_s;
    logic [PW-1:0]           r_rhs;
    logic signed [MW-1:0]    r_n;
    logic                    r_far;
    logic [bzf_pkg::LIMIT_W-1:0] r_limit;
    logic                    r_valid;
    logic [C-1:0]            r_ox0, r_oy0, r_ox1, r_oy1;
    logic                    r_olast;

    logic signed [MW-1:0]    m_a, m_b;
    logic signed [PW-1:0]    m_p;
    logic signed [DW-1:0]    a_d, b_d, dx_k, dy_k;
    logic [C-1:0]            px_k, py_k;
    logic [MW-1:0]           un;
    logic                    near;
    logic [C-1:0]            lx [4], ly [4], rx [4], ry [4];
    logic [EW-1:0]           st_wdata, st_rdata;
    logic                    st_we;

    function automatic logic [C-1:0] mid(input logic [C-1:0] a, input logic [C-1:0] b);
        logic [C:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[C:1];
    endfunction

    function automatic void halves(input logic [C-1:0] v [4],
                                   output logic [C-1:0] l [4],
                                   output logic [C-1:0] r [4]);
        logic [C-1:0] a1, a2, a3, b1, b2, c1;
        a1 = mid(v[0], v[1]);
        a2 = mid(v[1], v[2]);
        a3 = mid(v[2], v[3]);
        b1 = mid(a1, a2);
        b2 = mid(a2, a3);
        c1 = mid(b1, b2);
        l[0] = v[0]; l[1] = a1; l[2] = b1; l[3] = c1;
        r[0] = c1;   r[1] = b2; r[2] = a3; r[3] = v[3];
    endfunction

    always_comb begin
        halves(r_px, lx, rx);
        halves(r_py, ly, ry);
    end

    assign px_k = r_k ? r_px[2] : r_px[1];
    assign py_k = r_k ? r_py[2] : r_py[1];
    assign a_d  = $signed({1'b0, r_py[0]}) - $signed({1'b0, r_py[3]});
    assign b_d  = $signed({1'b0, r_px[3]}) - $signed({1'b0, r_px[0]});
    assign dx_k = $signed({1'b0, px_k}) - $signed({1'b0, r_px[0]});
    assign dy_k = $signed({1'b0, py_k}) - $signed({1'b0, r_py[0]});
    assign un   = r_n[MW-1] ? MW'(-r_n) : MW'(r_n);
    assign near = !r_far && ($unsigned(m_p) < r_rhs);

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_AA: begin
                m_a = MW'(a_d);
                m_b = MW'(a_d);
            end
            S_BB: begin
                m_a = MW'(b_d);
                m_b = MW'(b_d);
            end
            S_LL: begin
                m_a = $signed(MW'(r_limit));
                m_b = $signed(MW'(r_limit));
            end
            S_LS: begin
                m_a = $signed(m_p[MW-1:0]);
                m_b = r_s;
            end
            S_NA: begin
                m_a = MW'(a_d);
                m_b = MW'(dx_k);
            end
            S_NB: begin
                m_a = MW'(b_d);
                m_b = MW'(dy_k);
            end
            S_NN: begin
                m_a = $signed(un);
                m_b = $signed(un);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    bzf_mul #(.W(MW)) u_mul (
        .i_clk (i_clk),
        .i_a   (m_a),
        .i_b   (m_b),
        .o_p   (m_p)
    );

    assign st_we    = (r_state == S_SPLIT);
    assign st_wdata = {r_lvl + 1'b1, ry[3], ry[2], ry[1], ry[0], rx[3], rx[2], rx[1], rx[0]};

    bzf_stk #(.DEPTH(SD), .DW(EW)) u_stk (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_sp[IW-1:0]),
        .i_wdata (st_wdata),
        .i_raddr (IW'(r_sp - 1'b1)),
        .o_rdata (st_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_valid <= 1'b0;
            r_limit <= bzf_pkg::LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (r_valid && i_ready && r_state != S_EMIT) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_px[0] <= i_p0_x; r_px[1] <= i_p1_x;
                        r_px[2] <= i_p2_x; r_px[3] <= i_p3_x;
                        r_py[0] <= i_p0_y; r_py[1] <= i_p1_y;
                        r_py[2] <= i_p2_y; r_py[3] <= i_p3_y;
                        r_lvl   <= '0;
                        r_sp    <= '0;
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    r_state <= (32'(r_lvl) >= MAX_DEPTH) ? S_EMIT : S_AA;
                end
                S_AA: r_state <= S_BB;
                S_BB: begin
                    r_s     <= m_p[MW-1:0];
                    r_state <= S_LL;
                end
                S_LL: begin
                    r_s     <= r_s + m_p[MW-1:0];
                    r_state <= S_LS;
                end
                S_LS: r_state <= S_RH;
                S_RH: begin
                    r_rhs   <= $unsigned(m_p);
                    r_k     <= 1'b0;
                    r_state <= S_NA;
                end
                S_NA: r_state <= S_NB;
                S_NB: begin
                    r_n     <= m_p[MW-1:0];
                    r_state <= S_NS;
                end
                S_NS: begin
                    r_n     <= r_n + m_p[MW-1:0];
                    r_state <= S_NN;
                end
                S_NN: begin
                    r_far   <= (un >> 32) != '0;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (!near) begin
                        r_state <= S_SPLIT;
                    end else if (!r_k) begin
                        r_k     <= 1'b1;
                        r_state <= S_NA;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_SPLIT: begin
                    r_sp    <= r_sp + 1'b1;
                    r_px    <= lx;
                    r_py    <= ly;
                    r_lvl   <= r_lvl + 1'b1;
                    r_state <= S_TEST;
                end
                S_EMIT: begin
                    if (!r_valid || i_ready) begin
                        r_valid <= 1'b1;
                        r_ox0   <= r_px[0];
                        r_oy0   <= r_py[0];
                        r_ox1   <= r_px[3];
                        r_oy1   <= r_py[3];
                        r_olast <= (r_sp == '0);
                        r_state <= (r_sp == '0) ? S_IDLE : S_POP;
                    end
                end
                S_POP: begin
                    r_sp    <= r_sp - 1'b1;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    for (int i = 0; i < 4; i++) begin
                        r_px[i] <= st_rdata[i*C +: C];
                        r_py[i] <= st_rdata[(4+i)*C +: C];
                    end
                    r_lvl   <= st_rdata[8*C +: LW];
                    r_state <= S_TEST;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_valid;
    assign o_seg_x0   = r_ox0;
    assign o_seg_y0   = r_oy0;
    assign o_seg_x1   = r_ox1;
    assign o_seg_y1   = r_oy1;
    assign o_seg_last = r_olast;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_sp) <= SD)
        else $error("stack pointer beyond stack depth");
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && o_ready |-> r_sp == '0)
        else $error("stack not empty while idle");
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready right after taking a curve");
    a_push_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SPLIT |-> 32'(r_lvl) < MAX_DEPTH)
        else $error("split at maximum depth");
`endif

endmodule
